/* src/bcpc_pkg.sv */
// ----------------------------------------------------------------------------
// bcpc_pkg
// Shared types and constants for the bone chain pose composer.
// ----------------------------------------------------------------------------
package bcpc_pkg;

  localparam int MaxBones = 64;
  localparam int MaxChain = 16;
  localparam int BoneW = $clog2(MaxBones);
  localparam int ChainW = $clog2(MaxChain);
  localparam int QShift = 14;
  localparam logic signed [15:0] QOne = 16'sd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK,
    ST_COMP_RD,
    ST_COMP,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;        // store the input item's bone entry
    logic rd_en;        // read table entry at rd_addr
    logic [BoneW-1:0] rd_addr;
    logic init;         // clear position, load identity rotation
    logic start_step;   // start composing the entry just read
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic step_done;
    logic has_parent;
    logic [BoneW-1:0] parent;
  } dp_sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

/* src/bcpc_datapath.sv */
// ----------------------------------------------------------------------------
// bcpc_datapath
// Bone table memory and a shared-multiplier composer: one 35x16 product
// per cycle, sequenced by a micro-step counter.
// ----------------------------------------------------------------------------
module bcpc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bcpc_pkg::dp_cmd_t    cmd,
  output bcpc_pkg::dp_sts_t    sts,
  input  logic [5:0]           wr_addr,
  input  logic [6:0]           wr_link,
  input  logic [95:0]          wr_trans,
  input  logic [63:0]          wr_rot,
  output logic [95:0]          pos,
  output logic [63:0]          rot
);

  logic [6:0]  link_mem [bcpc_pkg::MaxBones];
  logic [95:0] trans_mem [bcpc_pkg::MaxBones];
  logic [63:0] rot_mem [bcpc_pkg::MaxBones];
  logic [6:0]  link_r;
  logic [95:0] trans_r;
  logic [63:0] lrot_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      link_mem[wr_addr] <= wr_link;
      trans_mem[wr_addr] <= wr_trans;
      rot_mem[wr_addr] <= wr_rot;
    end
    if (cmd.rd_en) begin
      link_r <= link_mem[cmd.rd_addr];
      trans_r <= trans_mem[cmd.rd_addr];
      lrot_r <= rot_mem[cmd.rd_addr];
    end
  end

  assign sts.has_parent = link_r[6];
  assign sts.parent = link_r[5:0];

  // Micro-steps: 0..5 cross products for t, 6..11 second cross, 12..14 w*t,
  // 15..30 Hamilton products, 31 finish. Each step multiplies one pair and
  // accumulates into acc_r; the accumulator is shifted and stored at group end.
  // t needs 35 bits; position terms only need the sum modulo 2^46.
  logic [4:0] step_r, step_nxt;
  logic       busy_r, busy_nxt;
  logic signed [31:0] pos_r [3];
  logic signed [15:0] q_r [4];
  logic signed [34:0] t_r [3];
  logic signed [47:0] acc_r;
  logic signed [15:0] qr [4];
  logic signed [15:0] ql [4];
  logic signed [31:0] v [3];
  logic signed [34:0] ma;
  logic signed [15:0] mb;
  logic signed [50:0] prod;
  logic               neg, last;
  logic [1:0]         dst;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qr[i] = q_r[i];
      ql[i] = lrot_r[16*i +: 16];
    end
    for (int i = 0; i < 3; i++) v[i] = trans_r[32*i +: 32];
    ma = '0; mb = '0; neg = 1'b0; last = 1'b0; dst = 2'd0;
    unique case (step_r)
      5'd0:  begin ma = 35'(v[2]); mb = qr[1]; end
      5'd1:  begin ma = 35'(v[1]); mb = qr[2]; neg = 1'b1; last = 1'b1; dst = 2'd0; end
      5'd2:  begin ma = 35'(v[0]); mb = qr[2]; end
      5'd3:  begin ma = 35'(v[2]); mb = qr[0]; neg = 1'b1; last = 1'b1; dst = 2'd1; end
      5'd4:  begin ma = 35'(v[1]); mb = qr[0]; end
      5'd5:  begin ma = 35'(v[0]); mb = qr[1]; neg = 1'b1; last = 1'b1; dst = 2'd2; end
      5'd6:  begin ma = t_r[2]; mb = qr[1]; end
      5'd7:  begin ma = t_r[1]; mb = qr[2]; neg = 1'b1; last = 1'b1; dst = 2'd0; end
      5'd8:  begin ma = t_r[0]; mb = qr[2]; end
      5'd9:  begin ma = t_r[2]; mb = qr[0]; neg = 1'b1; last = 1'b1; dst = 2'd1; end
      5'd10: begin ma = t_r[1]; mb = qr[0]; end
      5'd11: begin ma = t_r[0]; mb = qr[1]; neg = 1'b1; last = 1'b1; dst = 2'd2; end
      5'd12: begin ma = t_r[0]; mb = qr[3]; last = 1'b1; dst = 2'd0; end
      5'd13: begin ma = t_r[1]; mb = qr[3]; last = 1'b1; dst = 2'd1; end
      5'd14: begin ma = t_r[2]; mb = qr[3]; last = 1'b1; dst = 2'd2; end
      // x = rw*lx + rx*lw + ry*lz - rz*ly
      5'd15: begin ma = 35'(qr[3]); mb = ql[0]; end
      5'd16: begin ma = 35'(qr[0]); mb = ql[3]; end
      5'd17: begin ma = 35'(qr[1]); mb = ql[2]; end
      5'd18: begin ma = 35'(qr[2]); mb = ql[1]; neg = 1'b1; last = 1'b1; dst = 2'd0; end
      // y = rw*ly - rx*lz + ry*lw + rz*lx
      5'd19: begin ma = 35'(qr[3]); mb = ql[1]; end
      5'd20: begin ma = 35'(qr[0]); mb = ql[2]; neg = 1'b1; end
      5'd21: begin ma = 35'(qr[1]); mb = ql[3]; end
      5'd22: begin ma = 35'(qr[2]); mb = ql[0]; last = 1'b1; dst = 2'd1; end
      // z = rw*lz + rx*ly - ry*lx + rz*lw
      5'd23: begin ma = 35'(qr[3]); mb = ql[2]; end
      5'd24: begin ma = 35'(qr[0]); mb = ql[1]; end
      5'd25: begin ma = 35'(qr[1]); mb = ql[0]; neg = 1'b1; end
      5'd26: begin ma = 35'(qr[2]); mb = ql[3]; last = 1'b1; dst = 2'd2; end
      // w = rw*lw - rx*lx - ry*ly - rz*lz
      5'd27: begin ma = 35'(qr[3]); mb = ql[3]; end
      5'd28: begin ma = 35'(qr[0]); mb = ql[0]; neg = 1'b1; end
      5'd29: begin ma = 35'(qr[1]); mb = ql[1]; neg = 1'b1; end
      5'd30: begin ma = 35'(qr[2]); mb = ql[2]; neg = 1'b1; last = 1'b1; dst = 2'd3; end
      default: ;
    endcase
    prod = ma * mb;
  end

  logic signed [47:0] sum;
  logic signed [33:0] shf;
  assign sum = neg ? acc_r - 48'(prod) : acc_r + 48'(prod);
  assign shf = 34'(sum >>> bcpc_pkg::QShift);

  // Hamilton results are held until the rotation step finishes using the old R
  logic signed [15:0] nq_r [4];

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (cmd.start_step) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      if (step_r == 5'd31) busy_nxt = 1'b0;
      else step_nxt = step_r + 5'd1;
    end
  end

  assign sts.step_done = busy_r && (step_r == 5'd31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < 3; i++) pos_r[i] <= '0;
      q_r[0] <= '0; q_r[1] <= '0; q_r[2] <= '0; q_r[3] <= bcpc_pkg::QOne;
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r == 5'd31) begin
        for (int i = 0; i < 4; i++) q_r[i] <= nq_r[i];
      end else if (last) begin
        acc_r <= '0;
        if (step_r <= 5'd5) begin
          t_r[dst] <= {shf, 1'b0};
        end else if (step_r <= 5'd14) begin
          pos_r[dst] <= pos_r[dst] + 32'(shf);
        end else begin
          nq_r[dst] <= bcpc_pkg::sat16(sum >>> bcpc_pkg::QShift);
        end
      end else begin
        acc_r <= sum;
      end
      // add the translation itself once
      if (step_r == 5'd0)
        for (int i = 0; i < 3; i++) pos_r[i] <= pos_r[i] + v[i];
    end
  end

  assign pos = {pos_r[2], pos_r[1], pos_r[0]};
  assign rot = {q_r[3], q_r[2], q_r[1], q_r[0]};

endmodule

/* src/bcpc_ctrl.sv */
// ----------------------------------------------------------------------------
// bcpc_ctrl
// Controller: accept beats, walk the parent chain, sequence the composer.
// ----------------------------------------------------------------------------
module bcpc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               in_query,
  input  logic [5:0]         in_bone,
  input  logic               out_fire,
  output logic               in_rdy,
  output logic               out_vld,
  output logic [4:0]         depth,
  output logic               more,
  output bcpc_pkg::dp_cmd_t  cmd,
  input  bcpc_pkg::dp_sts_t  sts
);

  bcpc_pkg::state_t state_r, state_nxt;
  logic [5:0] chain_r [bcpc_pkg::MaxChain];
  logic [4:0] depth_r, depth_nxt;
  logic [4:0] k_r, k_nxt;
  logic       more_r, more_nxt;
  logic [5:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    k_nxt = k_r;
    more_nxt = more_r;
    idx_nxt = idx_r;
    cmd = '0;
    in_rdy = 1'b0;
    out_vld = 1'b0;
    unique case (state_r)
      bcpc_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.wr_en = !in_query;
          if (in_query) begin
            cmd.rd_en = 1'b1;
            cmd.rd_addr = in_bone;
            idx_nxt = in_bone;
            depth_nxt = '0;
            state_nxt = bcpc_pkg::ST_WALK;
          end
        end
      end
      bcpc_pkg::ST_WALK: begin
        depth_nxt = depth_r + 5'd1;
        more_nxt = sts.has_parent;
        idx_nxt = sts.parent;
        if (sts.has_parent && (depth_r + 5'd1 < 5'(bcpc_pkg::MaxChain))) begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = sts.parent;
        end else begin
          k_nxt = depth_r;
          cmd.init = 1'b1;
          state_nxt = bcpc_pkg::ST_COMP_RD;
        end
      end
      bcpc_pkg::ST_COMP_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = chain_r[k_r[3:0]];
        state_nxt = bcpc_pkg::ST_COMP;
      end
      bcpc_pkg::ST_WALK_RD: begin
        cmd.start_step = 1'b1;
        state_nxt = bcpc_pkg::ST_COMP;
      end
      bcpc_pkg::ST_COMP: begin
        if (sts.step_done) begin
          if (k_r == 5'd0) state_nxt = bcpc_pkg::ST_OUT;
          else begin
            k_nxt = k_r - 5'd1;
            state_nxt = bcpc_pkg::ST_COMP_RD;
          end
        end else if (k_r[4]) begin
          state_nxt = state_r;
        end
      end
      bcpc_pkg::ST_OUT: begin
        out_vld = 1'b1;
        if (out_fire) state_nxt = bcpc_pkg::ST_IDLE;
      end
      default: state_nxt = bcpc_pkg::ST_IDLE;
    endcase
    // after a composition read, launch the step from the next state
    if (state_r == bcpc_pkg::ST_COMP_RD) state_nxt = bcpc_pkg::ST_WALK_RD;
  end

  always_ff @(posedge clk) begin
    if (state_r == bcpc_pkg::ST_WALK) chain_r[depth_r[3:0]] <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcpc_pkg::ST_IDLE;
      depth_r <= '0;
      k_r <= '0;
      more_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      k_r <= (state_r == bcpc_pkg::ST_WALK && state_nxt == bcpc_pkg::ST_COMP_RD)
             ? depth_r : k_nxt;
      more_r <= more_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign depth = depth_r;
  assign more = more_r;

endmodule

/* src/bone_chain_pose_compose.sv */
// Query flow: L walk reads along the parent chain (L = chain length), then
// one composition step per bone, root first.
// One item at a time: a new beat is accepted only after the last result is taken;
// composition uses one shared 35x16 multiplier stepping through 31 products per bone.
// Reset: synchronous active-low rst_n clears controller and step counter;
// the bone table is not cleared and reads undefined until written.
// ----------------------------------------------------------------------------
// bone_chain_pose_compose
// Model-space pose of a bone by composing its parent chain root first.
// ----------------------------------------------------------------------------
module bone_chain_pose_compose (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[0], bone_index[6:1], parent_index[12:7], has_parent[13],
  // local_x[45:14], local_y[77:46], local_z[109:78], local_qx..qw[173:110]
  input  logic [175:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], rot_x..w[159:96],
  // chain_length[164:160], chain_truncated[165]
  output logic [167:0] out_tdata
);

  bcpc_pkg::dp_cmd_t cmd;
  bcpc_pkg::dp_sts_t sts;
  logic        in_fire, out_fire;
  logic [4:0]  depth;
  logic        more;
  logic [95:0] pos;
  logic [63:0] rot;

  // accept a beat only while idle
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  bcpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_fire), .in_query(in_tdata[0]), .in_bone(in_tdata[6:1]),
    .out_fire(out_fire), .in_rdy(in_tready), .out_vld(out_tvalid),
    .depth(depth), .more(more), .cmd(cmd), .sts(sts)
  );

  bcpc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .wr_addr(in_tdata[6:1]),
    .wr_link({in_tdata[13], in_tdata[12:7]}),
    .wr_trans(in_tdata[109:14]),
    .wr_rot(in_tdata[173:110]),
    .pos(pos), .rot(rot)
  );

  // hold result in the datapath registers until the beat is taken
  assign out_tdata = {2'b00, more, depth, rot, pos};

`ifndef ASSERT_OFF
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (depth != 5'd0 && depth <= 5'd16)) else $error("bad chain length");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
`endif

endmodule

/* sim/bone_chain_pose_compose_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bone_chain_pose_compose_tb
// Self-checking bench: writes bone tables, queries poses and checks each pose
// against a fixed-point forward-kinematics predictor, under random stalls.
// ----------------------------------------------------------------------------
module bone_chain_pose_compose_tb;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;
  localparam int NumRandom = 1930;
  localparam int CycleLimit = 8000000;

  typedef struct packed {
    logic signed [15:0] qw, qz, qy, qx;
    logic signed [31:0] z, y, x;
    logic        has_parent;
    logic [5:0]  parent;
    logic [5:0]  bone;
    logic        cmd;
  } beat_t;

  typedef struct packed {
    logic        trunc;
    logic [4:0]  len;
    logic signed [15:0] rw, rz, ry, rx;
    logic signed [31:0] pz, py, px;
  } pose_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [175:0] in_tdata;
  logic [167:0] out_tdata;

  bone_chain_pose_compose i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor copy of the bone table
  logic [6:0]  bone_link [bcpc_pkg::MaxBones];
  logic signed [31:0] bone_tx [bcpc_pkg::MaxBones], bone_ty [bcpc_pkg::MaxBones],
                      bone_tz [bcpc_pkg::MaxBones];
  logic signed [15:0] bone_q [bcpc_pkg::MaxBones][4];
  bit written [bcpc_pkg::MaxBones];

  pose_t expected_poses[$];
  int errors = 0;
  int n_queries = 0, n_trunc = 0, n_poses = 0;
  bit stimulus_done = 0;
  bit long_hold = 0;
  bit calm = 0;
  longint cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint fdiv14(longint v);
    return v >>> bcpc_pkg::QShift;  // arithmetic shift floors
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // compose the chain of the queried bone, root first
  function automatic pose_t compose_pose(logic [5:0] bone);
    int chain[bcpc_pkg::MaxChain];
    int depth = 0;
    int idx = int'(bone);
    bit more = 1;
    logic [31:0] pos[3];
    longint r[4], v[3], t[3], s[3], l[4], nr[4];
    pose_t p;
    pos = '{0, 0, 0};
    r = '{0, 0, 0, 16384};
    while (more && depth < bcpc_pkg::MaxChain) begin
      chain[depth++] = idx;
      more = bone_link[idx][6];
      idx = int'(bone_link[idx][5:0]);
    end
    for (int k = depth - 1; k >= 0; k--) begin
      v[0] = longint'(bone_tx[chain[k]]);
      v[1] = longint'(bone_ty[chain[k]]);
      v[2] = longint'(bone_tz[chain[k]]);
      for (int i = 0; i < 4; i++) l[i] = longint'(bone_q[chain[k]][i]);
      t[0] = 2 * fdiv14(r[1] * v[2] - r[2] * v[1]);
      t[1] = 2 * fdiv14(r[2] * v[0] - r[0] * v[2]);
      t[2] = 2 * fdiv14(r[0] * v[1] - r[1] * v[0]);
      s[0] = v[0] + fdiv14(r[3] * t[0]) + fdiv14(r[1] * t[2] - r[2] * t[1]);
      s[1] = v[1] + fdiv14(r[3] * t[1]) + fdiv14(r[2] * t[0] - r[0] * t[2]);
      s[2] = v[2] + fdiv14(r[3] * t[2]) + fdiv14(r[0] * t[1] - r[1] * t[0]);
      for (int i = 0; i < 3; i++) pos[i] = pos[i] + s[i][31:0];
      nr[0] = clamp16(fdiv14(r[3] * l[0] + r[0] * l[3] + r[1] * l[2] - r[2] * l[1]));
      nr[1] = clamp16(fdiv14(r[3] * l[1] - r[0] * l[2] + r[1] * l[3] + r[2] * l[0]));
      nr[2] = clamp16(fdiv14(r[3] * l[2] + r[0] * l[1] - r[1] * l[0] + r[2] * l[3]));
      nr[3] = clamp16(fdiv14(r[3] * l[3] - r[0] * l[0] - r[1] * l[1] - r[2] * l[2]));
      r = nr;
    end
    p.px = pos[0]; p.py = pos[1]; p.pz = pos[2];
    p.rx = r[0][15:0]; p.ry = r[1][15:0]; p.rz = r[2][15:0]; p.rw = r[3][15:0];
    p.len = depth[4:0];
    p.trunc = more;
    return p;
  endfunction

  // update the table or queue the pose the block must produce
  task automatic predict_beat(beat_t b);
    if (b.cmd == CmdWrite) begin
      bone_link[b.bone] = {b.has_parent, b.parent};
      bone_tx[b.bone] = b.x; bone_ty[b.bone] = b.y; bone_tz[b.bone] = b.z;
      bone_q[b.bone] = '{b.qx, b.qy, b.qz, b.qw};
      written[b.bone] = 1;
    end else begin
      expected_poses.push_back(compose_pose(b.bone));
      n_queries++;
    end
  endtask

  // offer one beat, hold until accepted, then now and then idle a random burst
  task automatic send_beat(beat_t b);
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_beat(b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic beat_t write_beat(int bone, int par, bit hp, logic [31:0] x,
                                       logic [31:0] y, logic [31:0] z,
                                       logic [15:0] qx, logic [15:0] qy,
                                       logic [15:0] qz, logic [15:0] qw);
    beat_t b;
    b.cmd = CmdWrite; b.bone = 6'(bone); b.parent = 6'(par); b.has_parent = hp;
    b.x = x; b.y = y; b.z = z; b.qx = qx; b.qy = qy; b.qz = qz; b.qw = qw;
    return b;
  endfunction

  // query beats carry random junk in the unused fields
  function automatic beat_t query_beat(int bone);
    beat_t b;
    b = 174'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    b.cmd = CmdQuery;
    b.bone = 6'(bone);
    return b;
  endfunction

  function automatic logic [15:0] rand_quat();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 32767) - 16384);
      2: return 16'd16384;
      default: return 16'd0;
    endcase
  endfunction

  function automatic beat_t random_write(int bone, int top);
    bit hp = $urandom_range(0, 7) != 0;
    int par = written[top] ? top : bone;
    if ($urandom_range(0, 9) == 0) par = $urandom_range(0, 63);
    if (!written[par]) hp = 0;
    return write_beat(bone, par, hp, $urandom, $urandom >>> $urandom_range(0, 31),
                      $urandom_range(0, 1) ? $urandom : 32'h8000_0000 >> $urandom_range(0, 31),
                      rand_quat(), rand_quat(), rand_quat(), rand_quat());
  endfunction

  // ---- directed table ----
  beat_t directed[$];
  bit    dir_has_pose[$];
  pose_t dir_pose[$];

  task automatic add_row(beat_t b, bit has, pose_t p);
    directed.push_back(b);
    dir_has_pose.push_back(has);
    dir_pose.push_back(p);
  endtask

  // ---- sender ----
  initial begin
    pose_t typed;
    int nxt;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // parentless root with identity rotation: pose reads back its own entry
    add_row(write_beat(0, 0, 0, 32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff,
                       0, 0, 0, 16'sd16384), 0, '0);
    typed = {1'b0, 5'd1, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
             32'h7fff_ffff, 32'hffff_0000, 32'h0001_0000};
    add_row(query_beat(0), 1, typed);
    // extreme fields
    add_row(write_beat(63, 0, 1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                       16'h8000, 16'h7fff, 16'h8000, 16'h7fff), 0, '0);
    add_row(query_beat(63), 0, '0);
    add_row(write_beat(1, 63, 1, 32'hffff_ffff, 0, 32'h1234_5678,
                       16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 0, '0);
    add_row(query_beat(1), 0, '0);
    // self parent cycle: walk stops at the chain limit with truncation set
    add_row(write_beat(2, 2, 1, 32'h0000_1000, 0, 0, 0, 0, 0, 16'sd16384), 0, '0);
    typed = {1'b1, 5'd16, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
             32'h0, 32'h0, 32'h0001_0000};
    add_row(query_beat(2), 1, typed);
    // a 20-deep linear chain, queried at several depths
    for (int i = 10; i < 30; i++)
      add_row(write_beat(i, i - 1, i != 10, 32'h0002_0000, 32'h0000_8000, 0,
                         16'sd0, 16'sd0, 16'sd6270, 16'sd15137), 0, '0);
    add_row(query_beat(10), 0, '0);
    add_row(query_beat(25), 0, '0);
    add_row(query_beat(26), 0, '0);
    add_row(query_beat(29), 0, '0);

    foreach (directed[i]) begin
      send_beat(directed[i]);
      if (dir_has_pose[i] && expected_poses.size() > 0 &&
          expected_poses[$] !== dir_pose[i]) begin
        $display("%0t: typed pose row %0d: expected %h predicted %h", $time, i,
                 dir_pose[i], expected_poses[$]);
        errors++;
      end
    end

    // hold the receiver off while queries are offered
    long_hold = 1;
    for (int i = 0; i < 6; i++) send_beat(query_beat(20 + i));
    long_hold = 0;

    // random: mostly writes building chains, mixed with queries of written bones
    nxt = 30;
    for (int i = 0; i < NumRandom; i++) begin
      if (i > NumRandom - 200) calm = 1;
      if ($urandom_range(0, 2) != 0) begin
        int bone, top;
        bone = $urandom_range(0, 63);
        top = (bone + 63) % 64;
        if ($urandom_range(0, 1)) begin
          bone = nxt;
          top = (nxt + 63) % 64;
          nxt = (nxt + 1) % 64;
        end
        send_beat(random_write(bone, top));
      end else begin
        int q;
        do q = $urandom_range(0, 63); while (!written[q]);
        send_beat(query_beat(q));
      end
    end
    in_tvalid <= 1'b0;
    stimulus_done = 1;
  end

  // ---- receiver: random stalls, one long hold-off ----
  initial begin
    bit hold_done;
    hold_done = 0;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_done = 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // ---- checker ----
  always @(posedge clk) begin
    pose_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[165:0];
      if (expected_poses.size() == 0) begin
        $display("%0t: unexpected pose beat %h", $time, got);
        errors++;
      end else begin
        want = expected_poses.pop_front();
        n_poses++;
        if (want.trunc) n_trunc++;
        if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz) begin
          $display("%0t: position expected %h %h %h actual %h %h %h", $time,
                   want.px, want.py, want.pz, got.px, got.py, got.pz);
          errors++;
        end
        if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz ||
            got.rw !== want.rw) begin
          $display("%0t: rotation expected %h %h %h %h actual %h %h %h %h", $time,
                   want.rx, want.ry, want.rz, want.rw, got.rx, got.ry, got.rz, got.rw);
          errors++;
        end
        if (got.len !== want.len || got.trunc !== want.trunc) begin
          $display("%0t: chain expected %0d/%0b actual %0d/%0b", $time,
                   want.len, want.trunc, got.len, got.trunc);
          errors++;
        end
      end
    end
  end

  // ---- end of run and watchdog ----
  initial begin
    while (!stimulus_done && cycles < CycleLimit) @(posedge clk);
    while (expected_poses.size() != 0 && cycles < CycleLimit) @(posedge clk);
    repeat (700) @(posedge clk);
    if (cycles >= CycleLimit) begin
      $display("watchdog: %0d poses still outstanding", expected_poses.size());
      $display("end of test: mismatches");
    end else begin
      $display("covered %0d queries (%0d truncated chains), %0d poses checked",
               n_queries, n_trunc, n_poses);
      if (errors == 0)
        $display("end of test: clean");
      else
        $display("end of test: mismatches");
    end
    $finish;
  end

  always @(posedge clk) cycles <= cycles + 1;

endmodule
